@@ src/eap_pkg.sv @@
// ----------------------------------------------------------------------------
// eap_pkg
// Shared constants and types for the embedded absence penalty block.
// ----------------------------------------------------------------------------
package eap_pkg;

  localparam int COLUMNS_DEF  = 64;
  localparam int MAX_ROWS_DEF = 1024;
  localparam int ROW_W        = 64;
  localparam int CFG_W        = 7;
  localparam int TOTAL_W      = 16;
  localparam int GROUP        = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef struct packed {
    logic valid;
    logic last;
    logic pend_sat;
  } eap_ctl_t;

endpackage

@@ src/eap_columns.sv @@
// ----------------------------------------------------------------------------
// eap_columns
// Per-column seen-one flags and pending zero counters; registers the amount
// each column adds to the total for the accepted row.
// ----------------------------------------------------------------------------
module eap_columns #(
  parameter int COLUMNS  = eap_pkg::COLUMNS_DEF,
  parameter int MAX_ROWS = eap_pkg::MAX_ROWS_DEF,
  localparam int PEND_W  = $clog2(MAX_ROWS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            take,
  input  logic                            load,
  input  logic [eap_pkg::ROW_W-1:0]       row_bits,
  input  logic                            last_row,
  input  logic [eap_pkg::CFG_W-1:0]       active_columns,
  output logic [COLUMNS-1:0][PEND_W-1:0]  amount_r,
  output eap_pkg::eap_ctl_t               ctl_r
);

  localparam logic [PEND_W-1:0] LIMIT = PEND_W'(MAX_ROWS - 1);
  localparam logic [eap_pkg::CFG_W-1:0] NCOL = eap_pkg::CFG_W'(COLUMNS);

  logic [COLUMNS-1:0]             seen_r;
  logic [COLUMNS-1:0]             seen_nxt;
  logic [COLUMNS-1:0][PEND_W-1:0] pend_r;
  logic [COLUMNS-1:0][PEND_W-1:0] pend_nxt;
  logic [COLUMNS-1:0][PEND_W-1:0] amount_nxt;
  logic [eap_pkg::CFG_W-1:0]      n_act;
  logic                           psat;
  logic                           act;
  logic                           bit_in;
  logic                           full;

  always_comb begin
    n_act = (active_columns > NCOL) ? NCOL : active_columns;
    psat  = 1'b0;
    for (int c = 0; c < COLUMNS; c++) begin
      act    = eap_pkg::CFG_W'(c) < n_act;
      bit_in = row_bits[c];
      full   = pend_r[c] == LIMIT;
      amount_nxt[c] = (act && bit_in && seen_r[c]) ? pend_r[c] : '0;
      psat = psat | (act && !bit_in && seen_r[c] && full);
      seen_nxt[c] = act ? (seen_r[c] | bit_in) : seen_r[c];
      if (!act) begin
        pend_nxt[c] = pend_r[c];
      end else if (bit_in) begin
        pend_nxt[c] = '0;
      end else if (seen_r[c] && !full) begin
        pend_nxt[c] = pend_r[c] + PEND_W'(1);
      end else begin
        pend_nxt[c] = pend_r[c];
      end
    end
    if (last_row) begin
      seen_nxt = '0;
      pend_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      pend_r <= '0;
      ctl_r  <= '0;
    end else begin
      if (take) begin
        seen_r <= seen_nxt;
        pend_r <= pend_nxt;
      end
      if (load) begin
        ctl_r.valid    <= take;
        ctl_r.last     <= last_row;
        ctl_r.pend_sat <= psat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      amount_r <= amount_nxt;
    end
  end

endmodule

@@ src/eap_adder.sv @@
// ----------------------------------------------------------------------------
// eap_adder
// First level of the column sum: registered sums over groups of eight.
// ----------------------------------------------------------------------------
module eap_adder #(
  parameter int COLUMNS  = eap_pkg::COLUMNS_DEF,
  parameter int MAX_ROWS = eap_pkg::MAX_ROWS_DEF,
  localparam int PEND_W  = $clog2(MAX_ROWS),
  localparam int NGROUP  = (COLUMNS + eap_pkg::GROUP - 1) / eap_pkg::GROUP,
  localparam int GW      = PEND_W + 3
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  eap_pkg::eap_ctl_t               ctl_in,
  input  logic [COLUMNS-1:0][PEND_W-1:0]  amount,
  output logic [NGROUP-1:0][GW-1:0]       grp_r,
  output eap_pkg::eap_ctl_t               ctl_r
);

  logic [NGROUP*eap_pkg::GROUP-1:0][PEND_W-1:0] pad;
  logic [NGROUP-1:0][GW-1:0]                    grp_nxt;

  always_comb begin
    pad = '0;
    pad[COLUMNS-1:0] = amount;
    for (int g = 0; g < NGROUP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < eap_pkg::GROUP; k++) begin
        grp_nxt[g] = grp_nxt[g] + GW'(pad[g*eap_pkg::GROUP + k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (load) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_nxt;
    end
  end

endmodule

@@ src/eap_accum.sv @@
// ----------------------------------------------------------------------------
// eap_accum
// Saturating running total, overflow flag and the result register.
// ----------------------------------------------------------------------------
module eap_accum #(
  parameter int COLUMNS  = eap_pkg::COLUMNS_DEF,
  parameter int MAX_ROWS = eap_pkg::MAX_ROWS_DEF,
  localparam int PEND_W  = $clog2(MAX_ROWS),
  localparam int NGROUP  = (COLUMNS + eap_pkg::GROUP - 1) / eap_pkg::GROUP,
  localparam int GW      = PEND_W + 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  eap_pkg::eap_ctl_t                 ctl,
  input  logic [NGROUP-1:0][GW-1:0]         grp,
  input  logic                              out_ready,
  output logic                              out_valid_r,
  output logic [eap_pkg::TOTAL_W-1:0]       out_total_r,
  output logic                              out_over_r,
  output logic                              adv
);

  localparam int CW    = GW + 3;
  localparam int ACC_W = ((CW > eap_pkg::TOTAL_W) ? CW : eap_pkg::TOTAL_W) + 1;
  localparam logic [ACC_W-1:0] TOT_MAX =
    {{(ACC_W - eap_pkg::TOTAL_W){1'b0}}, {eap_pkg::TOTAL_W{1'b1}}};

  logic [eap_pkg::TOTAL_W-1:0] total_r;
  logic [eap_pkg::TOTAL_W-1:0] total_nxt;
  logic                        sat_r;
  logic                        sat_nxt;
  logic [CW-1:0]               row_sum;
  logic [ACC_W-1:0]            acc;
  logic                        over;
  logic                        take2;

  always_comb begin
    row_sum = '0;
    for (int g = 0; g < NGROUP; g++) begin
      row_sum = row_sum + CW'(grp[g]);
    end
    acc       = ACC_W'(total_r) + ACC_W'(row_sum);
    over      = acc > TOT_MAX;
    total_nxt = over ? {eap_pkg::TOTAL_W{1'b1}} : acc[eap_pkg::TOTAL_W-1:0];
    sat_nxt   = sat_r | over | ctl.pend_sat;
  end

  assign adv   = !ctl.valid || !ctl.last || !out_valid_r || out_ready;
  assign take2 = ctl.valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (take2 && ctl.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (take2) begin
        if (ctl.last) begin
          total_r <= '0;
          sat_r   <= 1'b0;
        end else begin
          total_r <= total_nxt;
          sat_r   <= sat_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take2 && ctl.last) begin
      out_total_r <= total_nxt;
      out_over_r  <= sat_nxt;
    end
  end

endmodule

@@ src/embedded_absence_penalty.sv @@
// ----------------------------------------------------------------------------
// embedded_absence_penalty
// Saturated sum of zeros embedded in each matrix column, one row per cycle;
// input stalls only while a held result blocks the next final row.
// Rows pass column, adder and result registers. Reset clears, columns 64.
// ----------------------------------------------------------------------------
module embedded_absence_penalty #(
  parameter int COLUMNS  = eap_pkg::COLUMNS_DEF,
  parameter int MAX_ROWS = eap_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [eap_pkg::ROW_W-1:0]     in_tdata,   // [63:0] row_bits
  input  logic                          in_tlast,   // last_row
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [eap_pkg::TOTAL_W-1:0]   out_tdata,  // [15:0] penalty_total
  output logic                          out_tuser,  // [0] overflow
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [eap_pkg::CFG_W-1:0]     cfg_data    // active_columns
);

  localparam int PEND_W = $clog2(MAX_ROWS);
  localparam int NGROUP = (COLUMNS + eap_pkg::GROUP - 1) / eap_pkg::GROUP;
  localparam int GW     = PEND_W + 3;

  logic [eap_pkg::CFG_W-1:0]     active_r;
  logic [COLUMNS-1:0][PEND_W-1:0] amount;
  logic [NGROUP-1:0][GW-1:0]      grp;
  eap_pkg::eap_ctl_t              ctl1;
  eap_pkg::eap_ctl_t              ctl2;
  logic                           load1;
  logic                           load2;
  logic                           take;

  assign cfg_ready = 1'b1;
  assign load1     = !ctl1.valid || load2;
  assign in_tready = load1;
  assign take      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= eap_pkg::CFG_RESET;
    end else if (cfg_valid) begin
      active_r <= cfg_data;
    end
  end

  eap_columns #(
    .COLUMNS  (COLUMNS),
    .MAX_ROWS (MAX_ROWS)
  ) u_columns (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .load           (load1),
    .row_bits       (in_tdata),
    .last_row       (in_tlast),
    .active_columns (active_r),
    .amount_r       (amount),
    .ctl_r          (ctl1)
  );

  eap_adder #(
    .COLUMNS  (COLUMNS),
    .MAX_ROWS (MAX_ROWS)
  ) u_adder (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load2),
    .ctl_in (ctl1),
    .amount (amount),
    .grp_r  (grp),
    .ctl_r  (ctl2)
  );

  eap_accum #(
    .COLUMNS  (COLUMNS),
    .MAX_ROWS (MAX_ROWS)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl2),
    .grp         (grp),
    .out_ready   (out_tready),
    .out_valid_r (out_tvalid),
    .out_total_r (out_tdata),
    .out_over_r  (out_tuser),
    .adv         (load2)
  );

endmodule
